/* rtl/rcct_pkg.sv */
// Package for the chunk completion tracker: constants, opcodes and shared types.
// Used by every module of the tracker; depends on nothing.
`timescale 1ns / 1ps
package rcct_pkg;
	localparam int MAX_CHUNKS_DEF = 4096;
	localparam int STASH_DEPTH_DEF = 64;
	localparam int MAX_AGE_DEF = 256;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_COMPL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_MET = 2'd1;
	localparam logic [1:0] OUT_TIMEOUT = 2'd2;

	localparam logic CFG_RATIO = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam int IMM_SHIFT = 24;

	// Request from the stash walker or the completion path into the bitmap.
	typedef struct packed {
		logic        mark;
		logic [23:0] chunk;
	} rcct_mark_t;
endpackage

/* rtl/rcct_bitmap.sv */
// Chunk bitmap held in a synchronous memory with a read-modify-write mark port.
// A clearing pass sweeps the memory one word a cycle. Depends on rcct_pkg.
`timescale 1ns / 1ps
module rcct_bitmap import rcct_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clr_start,
	output logic                                clr_busy,
	input  rcct_mark_t                          req,
	input  logic [$clog2(MAX_CHUNKS+1)-1:0]     set_size,
	output logic                                newly_set
);
	localparam int AW = $clog2(MAX_CHUNKS);
	logic mem [MAX_CHUNKS];
	logic rd_s1;
	logic pend_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy <= 1'b1;
			clr_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= req.mark && (req.chunk < 24'(set_size)) && !clr_busy;
			if (clr_start) begin
				clr_busy <= 1'b1;
				clr_q <= '0;
			end else if (clr_busy) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(MAX_CHUNKS - 1))
					clr_busy <= 1'b0;
			end
		end
	end

	// Mark requests never arrive back to back, so write-back never
	// collides with the next read of the same entry.
	always_ff @(posedge clk) begin
		addr_s1 <= req.chunk[AW-1:0];
		rd_s1 <= mem[req.chunk[AW-1:0]];
		if (clr_busy)
			mem[clr_q] <= 1'b0;
		else if (pend_s1)
			mem[addr_s1] <= 1'b1;
	end

	assign newly_set = pend_s1 && !rd_s1;
endmodule

/* rtl/rdma_chunk_completion_tracker_core.sv */
// Top level of the chunk completion tracker: control sequencer, stash memory
// and result register. Depends on rcct_pkg and rcct_bitmap.
//
// Usage: items enter on in_valid/in_stall, results leave on out_valid/out_stall,
// one result per input transaction. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata); the user must see that it is used only while
// no transaction is in flight, as the block itself does not enforce this.
// Items are taken one at a time. A completion or tick item goes to ST_OUT when
// no wait is open and to ST_CHECK, where the count and the ratio products
// settle, when one is. A completion that goes to the stash first searches for
// a free slot, one slot a cycle. A start item clears the chunk bitmap one entry
// a cycle and then walks the stash entry by entry (read, mark if the bucket
// matches and the age is under MAX_AGE, ST_MARKW) before ST_CHECK.
// After reset the bitmap is cleared before the first item is taken. The result
// sits in an output register; while out_stall is high it holds, and the next
// item is taken but waits before it finishes.
`timescale 1ns / 1ps
module rdma_chunk_completion_tracker_core import rcct_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int STASH_DEPTH = STASH_DEPTH_DEF,
	parameter int MAX_AGE = MAX_AGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  start_bucket,
	input  logic [12:0] chunk_count,
	input  logic [7:0]  wc_status,
	input  logic        is_recv_with_imm,
	input  logic [31:0] imm_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        done_res,
	output logic [1:0]  outcome,
	output logic [12:0] completed_count,
	output logic [15:0] error_count,
	output logic [7:0]  last_error_status,
	output logic        stash_overflow,
	output logic [6:0]  stash_used
);
	localparam int SW = $clog2(MAX_CHUNKS + 1);
	localparam int IW = $clog2(STASH_DEPTH);
	localparam int CW = $clog2(STASH_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_MARKW = 3'd2;
	localparam logic [2:0] ST_CLR = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;
	localparam logic [2:0] ST_FIND = 3'd6;

	logic [2:0] state_q;
	logic [16:0] ratio_q;
	logic [31:0] tmo_q;
	logic [SW-1:0] done_q, size_q;
	logic [7:0] want_q;
	logic active_q;
	logic [31:0] elapsed_q, waitn_q;
	logic [15:0] fail_q;
	logic [7:0] fstat_q;
	logic drop_q;
	logic [CW-1:0] used_q;
	logic [STASH_DEPTH-1:0] valid_q;
	logic [1:0] op_q;
	logic [7:0] bkt_q;
	logic [23:0] chunk_q;
	logic [IW-1:0] idx_q;
	logic [1:0] wait_q;
	logic is_start_q;

	// Stash payload memory: bucket, deposit number, chunk.
	logic [63:0] smem [STASH_DEPTH];
	logic [63:0] srd_s1;
	logic swe;
	logic [IW-1:0] swa, sra;
	logic [63:0] swd;

	always_ff @(posedge clk) begin
		if (swe)
			smem[swa] <= swd;
		srd_s1 <= smem[sra];
	end

	rcct_mark_t mreq;
	logic clr_start, clr_busy, newly_set;

	rcct_bitmap #(.MAX_CHUNKS(MAX_CHUNKS)) u_bitmap (
		.clk(clk), .arst_n(arst_n), .clr_start(clr_start), .clr_busy(clr_busy),
		.req(mreq), .set_size(size_q), .newly_set(newly_set)
	);

	logic accept;
	assign in_stall = (state_q != ST_IDLE) || clr_busy;
	assign accept = in_valid && !in_stall;

	logic [7:0] age_bkt;
	logic [31:0] age;
	assign age_bkt = srd_s1[63:56];
	assign age = waitn_q - srd_s1[55:24];

	// Ratio products, registered before the compare.
	logic [SW+15:0] lhs_q;
	logic [SW+16:0] rhs_q;
	logic met;
	assign met = {1'b0, lhs_q} >= rhs_q;

	always_comb begin
		mreq = '0;
		clr_start = 1'b0;
		swe = 1'b0;
		swa = idx_q;
		swd = {bkt_q, waitn_q, chunk_q};
		sra = idx_q;
		if (state_q == ST_WALK && wait_q == 2'd1 && valid_q[idx_q] &&
		    age_bkt == want_q && age < 32'(MAX_AGE))
			mreq = '{mark: 1'b1, chunk: srd_s1[23:0]};
		if (state_q == ST_IDLE && accept && op == OP_COMPL && active_q &&
		    wc_status == 8'd0 && is_recv_with_imm &&
		    imm_word[31:IMM_SHIFT] == want_q)
			mreq = '{mark: 1'b1, chunk: imm_word[23:0]};
		if (state_q == ST_IDLE && accept && op == OP_START)
			clr_start = 1'b1;
		if (state_q == ST_FIND && !valid_q[idx_q])
			swe = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ratio_q <= 17'd65536;
			tmo_q <= 32'd1000;
			done_q <= '0; size_q <= '0; want_q <= '0; active_q <= 1'b0;
			elapsed_q <= '0; waitn_q <= '0; fail_q <= '0; fstat_q <= '0;
			drop_q <= 1'b0; used_q <= '0; valid_q <= '0;
			out_valid <= 1'b0; done_res <= 1'b0; outcome <= OUT_NONE;
			completed_count <= '0; error_count <= '0; last_error_status <= '0;
			stash_overflow <= 1'b0; stash_used <= '0;
			idx_q <= '0; wait_q <= '0; is_start_q <= 1'b0;
			op_q <= OP_START; bkt_q <= '0; chunk_q <= '0;
			lhs_q <= '0; rhs_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RATIO: ratio_q <= cfg_wdata[16:0];
					CFG_TIMEOUT: tmo_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (newly_set)
				done_q <= done_q + 1'b1;
			lhs_q <= {done_q, 16'd0};
			rhs_q <= ratio_q * size_q;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					op_q <= op;
					bkt_q <= imm_word[31:IMM_SHIFT];
					chunk_q <= imm_word[23:0];
					is_start_q <= 1'b0;
					wait_q <= 2'd0;
					unique case (op)
						OP_START: begin
							waitn_q <= waitn_q + 1'b1;
							done_q <= '0;
							want_q <= start_bucket;
							size_q <= (chunk_count > 13'(MAX_CHUNKS)) ? SW'(MAX_CHUNKS)
								: SW'(chunk_count);
							elapsed_q <= '0; fail_q <= '0; fstat_q <= '0;
							active_q <= 1'b1;
							is_start_q <= 1'b1;
							state_q <= ST_CLR;
						end
						OP_COMPL: begin
							if (active_q && wc_status != 8'd0) begin
								if (fail_q != 16'hFFFF) fail_q <= fail_q + 1'b1;
								fstat_q <= wc_status;
								state_q <= ST_CHECK;
							end else if (wc_status == 8'd0 && is_recv_with_imm &&
							    !(active_q && imm_word[31:IMM_SHIFT] == want_q)) begin
								idx_q <= '0;
								state_q <= ST_FIND;
							end else
								state_q <= active_q ? ST_CHECK : ST_OUT;
						end
						OP_TICK: begin
							if (active_q) begin
								if (elapsed_q != 32'hFFFFFFFF) elapsed_q <= elapsed_q + 1'b1;
								state_q <= ST_CHECK;
							end else
								state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_CLR: if (!clr_busy) begin
					idx_q <= '0;
					wait_q <= 2'd0;
					state_q <= ST_WALK;
				end
				ST_FIND: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						used_q <= used_q + 1'b1;
						state_q <= active_q ? ST_CHECK : ST_OUT;
					end else if (idx_q == IW'(STASH_DEPTH - 1)) begin
						drop_q <= 1'b1;
						state_q <= active_q ? ST_CHECK : ST_OUT;
					end else
						idx_q <= idx_q + 1'b1;
					wait_q <= 2'd0;
				end
				ST_WALK: begin
					if (wait_q == 2'd0)
						wait_q <= 2'd1;
					else begin
						if (valid_q[idx_q] && age_bkt == want_q) begin
							valid_q[idx_q] <= 1'b0;
							used_q <= used_q - 1'b1;
						end
						wait_q <= 2'd0;
						state_q <= ST_MARKW;
					end
				end
				ST_MARKW: begin
					if (idx_q == IW'(STASH_DEPTH - 1))
						state_q <= ST_CHECK;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_WALK;
					end
				end
				ST_CHECK: begin
					// The wait counter lets the count and the products settle before the compare.
					if (wait_q != 2'd2)
						wait_q <= wait_q + 1'b1;
					else if (!out_valid) begin
						out_valid <= 1'b1;
						// A tick only ever ends a wait by timeout.
						if (met && op_q != OP_TICK) begin
							done_res <= 1'b1; outcome <= OUT_MET; active_q <= 1'b0;
						end else if ((is_start_q || op_q == OP_TICK) &&
						    elapsed_q >= tmo_q) begin
							done_res <= 1'b1; outcome <= OUT_TIMEOUT; active_q <= 1'b0;
						end else begin
							done_res <= 1'b0; outcome <= OUT_NONE;
						end
						completed_count <= 13'(done_q);
						error_count <= fail_q;
						last_error_status <= fstat_q;
						stash_overflow <= drop_q;
						stash_used <= 7'(used_q);
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: if (!out_valid) begin
					out_valid <= 1'b1;
					done_res <= 1'b0;
					outcome <= OUT_NONE;
					completed_count <= 13'(done_q);
					error_count <= fail_q;
					last_error_status <= fstat_q;
					stash_overflow <= drop_q;
					stash_used <= 7'(used_q);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* verif/tb.sv */
// Self-checking testbench for rdma_chunk_completion_tracker_core.
// Depends on rcct_pkg and the tracker RTL; holds its own predictor of the tracker.
`timescale 1ns / 1ps
module tb;
	import rcct_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int BITMAP_DEPTH = MAX_CHUNKS_DEF;
	localparam int N_STASH = STASH_DEPTH_DEF;
	localparam int AGE_LIMIT = MAX_AGE_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1300;
	// Bucket reserved for the stash entry that must age out before it is drained.
	localparam logic [7:0] AGED_BUCKET = 8'hEE;

	typedef struct packed {
		logic        done;
		logic [1:0]  outcome;
		logic [12:0] completed;
		logic [15:0] errors;
		logic [7:0]  err_status;
		logic        overflow;
		logic [6:0]  used;
	} status_word_t;

	class tracker_scoreboard;
		bit          bitmap[BITMAP_DEPTH];
		int unsigned done_n, set_n;
		bit [7:0]    want;
		bit          active;
		bit [31:0]   elapsed, wait_no;
		bit [15:0]   fails;
		bit [7:0]    fail_st;
		bit          slot_v[N_STASH];
		bit [7:0]    slot_b[N_STASH];
		bit [31:0]   slot_w[N_STASH];
		bit [23:0]   slot_c[N_STASH];
		bit          dropped;
		bit [16:0]   ratio;
		bit [31:0]   timeout;
		status_word_t pending[$];
		int          mismatches, checked, waits_met, waits_timed;

		function new();
			ratio = 17'd65536;
			timeout = 32'd1000;
		endfunction

		function void mark(int unsigned c);
			if (c < set_n && !bitmap[c]) begin
				bitmap[c] = 1;
				done_n++;
			end
		endfunction

		function void stash(bit [7:0] b, bit [23:0] c);
			for (int i = 0; i < N_STASH; i++) begin
				if (!slot_v[i]) begin
					slot_v[i] = 1;
					slot_b[i] = b;
					slot_w[i] = wait_no;
					slot_c[i] = c;
					return;
				end
			end
			dropped = 1;
		endfunction

		function bit goal_reached();
			return 64'(done_n) * 64'd65536 >= 64'(ratio) * 64'(set_n);
		endfunction

		function void note(bit [1:0] op, bit [7:0] bucket, bit [12:0] count, bit [7:0] st,
				bit recv, bit [31:0] imm);
			status_word_t r;
			int n;
			r = '0;
			if (op == OP_START) begin
				wait_no++;
				foreach (bitmap[i]) bitmap[i] = 0;
				done_n = 0;
				want = bucket;
				set_n = (count > BITMAP_DEPTH) ? BITMAP_DEPTH : count;
				elapsed = 0;
				fails = 0;
				fail_st = 0;
				active = 1;
				for (int i = 0; i < N_STASH; i++) begin
					if (slot_v[i] && slot_b[i] == want) begin
						if (wait_no - slot_w[i] < AGE_LIMIT)
							mark(slot_c[i]);
						slot_v[i] = 0;
					end
				end
				if (goal_reached()) begin
					r.done = 1; r.outcome = OUT_MET; active = 0;
				end else if (elapsed >= timeout) begin
					r.done = 1; r.outcome = OUT_TIMEOUT; active = 0;
				end
			end else if (op == OP_COMPL) begin
				if (active) begin
					if (st != 0) begin
						if (fails != 16'hFFFF)
							fails++;
						fail_st = st;
					end else if (recv) begin
						if (imm[31:24] == want)
							mark(imm[23:0]);
						else
							stash(imm[31:24], imm[23:0]);
					end
					if (goal_reached()) begin
						r.done = 1; r.outcome = OUT_MET; active = 0;
					end
				end else if (st == 0 && recv) begin
					stash(imm[31:24], imm[23:0]);
				end
			end else if (op == OP_TICK && active) begin
				if (elapsed != 32'hFFFF_FFFF)
					elapsed++;
				if (elapsed >= timeout) begin
					r.done = 1; r.outcome = OUT_TIMEOUT; active = 0;
				end
			end
			n = 0;
			foreach (slot_v[i]) n += slot_v[i];
			r.completed = 13'(done_n);
			r.errors = fails;
			r.err_status = fail_st;
			r.overflow = dropped;
			r.used = 7'(n);
			pending.insert(pending.size(), r);
		endfunction

		function void compare(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, e, a);
			end
		endfunction

		function void check(status_word_t got);
			status_word_t e;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, expected none, got %h", $time, got);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.done && e.outcome == OUT_MET) waits_met++;
			if (e.done && e.outcome == OUT_TIMEOUT) waits_timed++;
			compare("done_res", e.done, got.done);
			compare("outcome", e.outcome, got.outcome);
			compare("completed_count", e.completed, got.completed);
			compare("error_count", e.errors, got.errors);
			compare("last_error_status", e.err_status, got.err_status);
			compare("stash_overflow", e.overflow, got.overflow);
			compare("stash_used", e.used, got.used);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [7:0]  start_bucket = '0;
	logic [12:0] chunk_count = '0;
	logic [7:0]  wc_status = '0;
	logic        is_recv_with_imm = 0;
	logic [31:0] imm_word = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        done_res;
	logic [1:0]  outcome;
	logic [12:0] completed_count;
	logic [15:0] error_count;
	logic [7:0]  last_error_status;
	logic        stash_overflow;
	logic [6:0]  stash_used;

	tracker_scoreboard sb = new();
	int send_idle = 0, recv_stall = 0, hold_cycles = 0, quiet_cycles = 0;
	int starts_sent = 0, items_sent = 0;

	rdma_chunk_completion_tracker_core uut (.*);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check({done_res, outcome, completed_count, error_count, last_error_status,
				stash_overflow, stash_used});
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: watchdog expired, %0d results still expected", $time,
				sb.pending.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(bit [1:0] o, bit [7:0] b, bit [12:0] n, bit [7:0] st, bit recv,
			bit [31:0] imm);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		op = o;
		start_bucket = b;
		chunk_count = n;
		wc_status = st;
		is_recv_with_imm = recv;
		imm_word = imm;
		do @(posedge clk); while (in_stall);
		sb.note(o, b, n, st, recv, imm);
		items_sent++;
		if (o == OP_START) starts_sent++;
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, bit [31:0] value);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 0;
		if (idx == CFG_RATIO) sb.ratio = value[16:0];
		else sb.timeout = value;
	endtask

	function automatic bit [7:0] pick_bucket();
		bit [7:0] b;
		b = 8'($urandom_range(255));
		return (b == AGED_BUCKET) ? 8'hEF : b;
	endfunction

	// One wait: a start, then mostly matching completions with some errors, ticks and noise.
	task automatic random_wait();
		bit [7:0] b;
		bit [12:0] n;
		int k, sel;
		b = pick_bucket();
		sel = $urandom_range(99);
		n = (sel < 4) ? 13'd0 : (sel < 8) ? 13'($urandom_range(8191)) : 13'($urandom_range(1, 12));
		send(OP_START, b, n, 8'd0, 1'b1, 32'd0);
		k = $urandom_range(1, 5);
		repeat (k) begin
			sel = $urandom_range(99);
			if (sel < 60)
				send(OP_COMPL, 8'($urandom), 13'($urandom), 8'd0, 1'b1,
					{b, 24'($urandom_range(n + 1))});
			else if (sel < 70)
				send(OP_COMPL, 8'($urandom), 13'($urandom), 8'($urandom_range(1, 255)),
					1'($urandom), $urandom);
			else if (sel < 82)
				send(OP_TICK, 8'($urandom), 13'($urandom), 8'($urandom), 1'($urandom),
					$urandom);
			else if (sel < 90)
				send(OP_COMPL, 8'($urandom), 13'($urandom), 8'd0, 1'b1,
					{pick_bucket(), 24'($urandom)});
			else if (sel < 95)
				send(OP_COMPL, 8'($urandom), 13'($urandom), 8'd0, 1'b0, $urandom);
			else
				send(OP_NONE, 8'($urandom), 13'($urandom), 8'($urandom), 1'($urandom),
					$urandom);
		end
	endtask

	initial begin
		bit [16:0] ratios[6];
		bit [31:0] timeouts[6];
		int phase_end;

		ratios = '{17'd65536, 17'd32768, 17'd0, 17'h1FFFF, 17'd65535, 17'd49152};
		timeouts = '{32'd1000, 32'd2, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1};
		repeat (9) @(negedge clk);
		arst_n = 1;

		// Directed: basic set, duplicates, out-of-range chunks, errors, idle stashing.
		send(OP_START, 8'd3, 13'd4, 8'd0, 1'b0, 32'd0);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0000);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0000);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0007);
		send(OP_COMPL, 8'd0, 13'd0, 8'hFF, 1'b1, 32'h0300_0001);
		send(OP_COMPL, 8'd0, 13'd0, 8'd1, 1'b0, 32'h0300_0001);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b0, 32'h0300_0001);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, {AGED_BUCKET, 24'd1});
		send(OP_TICK, 8'd0, 13'd0, 8'd0, 1'b0, 32'd0);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0001);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0002);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0300_0003);
		send(OP_COMPL, 8'd0, 13'd0, 8'h80, 1'b1, 32'h0500_0002);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0500_0002);
		send(OP_TICK, 8'd0, 13'd0, 8'd0, 1'b0, 32'd0);
		send(OP_NONE, 8'hFF, 13'h1FFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		send(OP_START, 8'd5, 13'd0, 8'd0, 1'b0, 32'd0);
		send(OP_START, 8'hFF, 13'h1FFF, 8'd0, 1'b0, 32'd0);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'hFFFF_FFFF);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'hFF00_0FFF);
		send(OP_START, 8'd0, 13'd4096, 8'd0, 1'b0, 32'd0);
		send(OP_COMPL, 8'd0, 13'd0, 8'd0, 1'b1, 32'h0000_0FFF);
		send(OP_START, 8'd0, 13'd4097, 8'd0, 1'b0, 32'd0);
		wait_results();

		phase_end = items_sent;
		for (int p = 0; p < 6; p++) begin
			write_cfg(CFG_RATIO, 32'(ratios[p]));
			write_cfg(CFG_TIMEOUT, timeouts[p]);
			for (int m = 0; m < 4; m++) begin
				send_idle = (m == 1 || m == 3) ? ((m == 1) ? 47 : 29) : 0;
				recv_stall = (m == 2 || m == 3) ? ((m == 2) ? 47 : 29) : 0;
				if (p == 1 && m == 0) begin
					// Hold the output off long enough that the input backs up.
					hold_cycles = 600;
					while (hold_cycles > 0)
						send(OP_TICK, 8'd0, 13'd0, 8'd0, 1'b0, 32'd0);
				end
				phase_end += RANDOM_ITEMS / 24;
				while (items_sent < phase_end)
					random_wait();
			end
			send_idle = 0;
			recv_stall = 0;
			wait_results();
		end

		// The entry deposited at the start is far older than the age limit by now.
		send(OP_START, AGED_BUCKET, 13'd4, 8'd0, 1'b0, 32'd0);
		wait_results();
		repeat (100) @(posedge clk);

		$display("Checked %0d results from %0d items over %0d waits (%0d met, %0d timed out).",
			sb.checked, items_sent, starts_sent, sb.waits_met, sb.waits_timed);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/rcct_pkg.sv
rtl/rcct_bitmap.sv
rtl/rdma_chunk_completion_tracker_core.sv
verif/tb.sv
